@@ rtl/core/slp_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants shared by the separated integer list parser.
// No dependencies; compile first.
package slp_pkg;

	localparam int VALUE_W = 30;
	localparam int CHAR_W  = 8;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_INITIAL   = 2'd0,
		PH_DIGIT     = 2'd1,
		PH_SEPARATOR = 2'd2,
		PH_ERROR     = 2'd3
	} phase_t;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	typedef struct packed {
		op_t               opcode;
		logic [CHAR_W-1:0] char_code;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CHAR_W-1:0]  separator;
		logic               final_res;
		logic               error;
		logic [VALUE_W-1:0] max_value;
	} res_t;

	typedef struct packed {
		logic emit;
		res_t res;
	} step_out_t;

endpackage

@@ rtl/core/slp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for parser requests and results.
// Depends on slp_pkg.
interface slp_item_if;
	import slp_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 opcode;
	logic [CHAR_W-1:0]   char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface slp_result_if;
	import slp_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [CHAR_W-1:0]   separator;
	logic                final_res;
	logic                error;
	logic [VALUE_W-1:0]  max_value;

	modport source (output valid, output value, output separator, output final_res,
		output error, output max_value, input ready);
	modport sink   (input valid, input value, input separator, input final_res,
		input error, input max_value, output ready);
endinterface

@@ rtl/core/separated_integer_list_parser_core.sv @@
`timescale 1ns / 1ps
// A request is captured in the input register when it is accepted, and any result it
// yields is then captured in the result register when the stage advances.
// Throughput: one request per cycle; a held result stalls requests once the input register is full.
// Reset: arst_n clears the parse state, running maximum and both valid flags.
// Depends on slp_pkg, slp_if and slp_step.
module separated_integer_list_parser_core #(
	parameter int MAX_DIGITS = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	slp_item_if.sink          item,
	slp_result_if.source      result
);
	import slp_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	item_t              item_s1;
	logic               item_valid_s1;
	phase_t             phase_q;
	logic [VALUE_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] rmax_q;
	res_t               res_q;
	logic               res_valid_q;

	phase_t             phase_nxt;
	logic [VALUE_W-1:0] acc_nxt;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [VALUE_W-1:0] rmax_nxt;
	step_out_t          step_out;
	logic               s1_go;

	// the stage advances when it holds a request and the result register is free or being drained
	assign s1_go      = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !item_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode    <= item.opcode;
			item_s1.char_code <= item.char_code;
		end
	end

	slp_step #(
		.MAX_DIGITS (MAX_DIGITS),
		.CNT_W      (CNT_W)
	) u_step (
		.phase_item (item_s1),
		.phase      (phase_q),
		.acc        (acc_q),
		.cnt        (cnt_q),
		.rmax       (rmax_q),
		.phase_nxt  (phase_nxt),
		.acc_nxt    (acc_nxt),
		.cnt_nxt    (cnt_nxt),
		.rmax_nxt   (rmax_nxt),
		.step_out   (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INITIAL;
			acc_q       <= '0;
			cnt_q       <= '0;
			rmax_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (s1_go) begin
			phase_q     <= phase_nxt;
			acc_q       <= acc_nxt;
			cnt_q       <= cnt_nxt;
			rmax_q      <= rmax_nxt;
			res_valid_q <= step_out.emit;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && step_out.emit) begin
			res_q <= step_out.res;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.value     = res_q.value;
	assign result.separator = res_q.separator;
	assign result.final_res = res_q.final_res;
	assign result.error     = res_q.error;
	assign result.max_value = res_q.max_value;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && (item_s1.opcode == OP_END)
		|=> (phase_q == PH_INITIAL) && (acc_q == '0) && (cnt_q == '0) && (rmax_q == '0))
		else $error("end request did not clear parse state");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) && !(s1_go && (item_s1.opcode == OP_END))
		|=> (phase_q == PH_ERROR))
		else $error("error phase left without end request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.error |-> res_q.final_res && (res_q.value == '0))
		else $error("error result with nonzero value");

	a_num_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.error
		|-> (res_q.value != '0) && (res_q.max_value >= res_q.value))
		else $error("number result not positive or above maximum");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond limit");
endmodule

@@ rtl/core/slp_step.sv @@
`timescale 1ns / 1ps
// Combinational step of the parser: character classes, next state and result.
// Depends on slp_pkg.
module slp_step #(
	parameter int MAX_DIGITS = 9,
	parameter int CNT_W      = 4
) (
	input  slp_pkg::item_t                phase_item,
	input  slp_pkg::phase_t               phase,
	input  logic [slp_pkg::VALUE_W-1:0]   acc,
	input  logic [CNT_W-1:0]              cnt,
	input  logic [slp_pkg::VALUE_W-1:0]   rmax,
	output slp_pkg::phase_t               phase_nxt,
	output logic [slp_pkg::VALUE_W-1:0]   acc_nxt,
	output logic [CNT_W-1:0]              cnt_nxt,
	output logic [slp_pkg::VALUE_W-1:0]   rmax_nxt,
	output slp_pkg::step_out_t            step_out
);
	import slp_pkg::*;

	logic [CHAR_W-1:0]  c;
	logic               is_end;
	logic               is_digit;
	logic               is_alpha;
	logic               is_space;
	logic               room;
	logic               acc_nz;
	logic               num_ok;
	logic [VALUE_W-1:0] acc_x10;
	logic [VALUE_W-1:0] max_upd;

	assign c        = phase_item.char_code;
	assign is_end   = (phase_item.opcode == OP_END);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_alpha = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
		|| ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
	assign is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	assign room     = (cnt < CNT_W'(MAX_DIGITS));
	assign acc_nz   = (acc != '0);
	// a number may be closed only from the digit phase and only if positive
	assign num_ok   = (phase == PH_DIGIT) && acc_nz;
	assign acc_x10  = (acc << 3) + (acc << 1) + VALUE_W'(c - CH_ZERO);
	assign max_upd  = (acc > rmax) ? acc : rmax;

	// next phase
	always_comb begin
		phase_nxt = phase;
		if (is_end) begin
			phase_nxt = PH_INITIAL;
		end else if (phase != PH_ERROR) begin
			if (is_digit) begin
				phase_nxt = room ? PH_DIGIT : PH_ERROR;
			end else if (is_alpha || is_space || !num_ok) begin
				phase_nxt = PH_ERROR;
			end else begin
				phase_nxt = PH_SEPARATOR;
			end
		end
	end

	// datapath and result
	always_comb begin
		acc_nxt  = acc;
		cnt_nxt  = cnt;
		rmax_nxt = rmax;
		step_out = '0;
		if (is_end) begin
			acc_nxt                 = '0;
			cnt_nxt                 = '0;
			rmax_nxt                = '0;
			step_out.emit           = 1'b1;
			step_out.res.final_res  = 1'b1;
			if (num_ok) begin
				step_out.res.value     = acc;
				step_out.res.max_value = max_upd;
			end else begin
				step_out.res.error     = 1'b1;
				step_out.res.max_value = rmax;
			end
		end else if (phase != PH_ERROR) begin
			if (is_digit) begin
				if (room) begin
					acc_nxt = acc_x10;
					cnt_nxt = cnt + CNT_W'(1);
				end
			end else if (!is_alpha && !is_space && num_ok) begin
				acc_nxt                = '0;
				cnt_nxt                = '0;
				rmax_nxt               = max_upd;
				step_out.emit          = 1'b1;
				step_out.res.value     = acc;
				step_out.res.separator = c;
				step_out.res.max_value = max_upd;
			end
		end
	end
endmodule
